>>> hdl/windowed_average_filter_core_macros.svh
// Assertion macros for the windowed average filter core.
// Used by the port checker; depends on nothing else.
`ifndef WINDOWED_AVERAGE_FILTER_CORE_MACROS_SVH
`define WINDOWED_AVERAGE_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define WAVG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wavg assertion failed");

// next-cycle implication
`define WAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wavg assertion failed");

`endif

>>> hdl/wavg_pkg.sv
// Shared constants and types of the windowed average filter.
// No dependencies.
package wavg_pkg;

	localparam int MAX_TAPS_DEF    = 10;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MIN_DEPTH       = 3;
	localparam int DEPTH_W         = 4;
	localparam int DIV_W           = DEPTH_W + 1;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(10);

	// history shift control handed to every cell
	typedef struct packed {
		logic en;
		logic clear;
	} wavg_shift_t;

endpackage

>>> hdl/wavg_if.sv
// Request channels of the windowed average filter: samples in, results out.
// Depends on wavg_pkg for default widths.
interface wavg_in_if #(
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface wavg_out_if #(
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          depth_ok;

	modport source (output valid, output filtered, output depth_ok, input ready);
	modport sink (input valid, input filtered, input depth_ok, output ready);
endinterface

>>> hdl/wavg_cell.sv
// One history cell: keeps the running sum of the newest IDX+1 samples.
// Depends on wavg_pkg for the shift control struct.
module wavg_cell #(
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + 4,
	parameter int IDX         = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wavg_pkg::wavg_shift_t           shift,
	input  logic [wavg_pkg::DEPTH_W-1:0]    depth,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic signed [SUM_W-1:0]         prev,
	output logic signed [SUM_W-1:0]         pfx,
	output logic signed [SUM_W-1:0]         tap
);

	logic signed [SUM_W-1:0] pfx_q;
	logic signed [SUM_W-1:0] base;

	assign base = shift.clear ? '0 : prev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q <= '0;
		end else if (shift.en) begin
			pfx_q <= SUM_W'(sample) + base;
		end
	end

	assign pfx = pfx_q;
	assign tap = (32'(depth) == 32'(IDX + 1)) ? pfx_q : '0;

endmodule

>>> hdl/wavg_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on wavg_pkg for the divisor width.
module wavg_div #(
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic signed [SUM_W-1:0]       sum,
	input  logic [wavg_pkg::DIV_W-1:0]    divisor,
	input  logic                          ok,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          depth_ok
);

	localparam int Q_W   = SAMPLE_BITS - 1;
	localparam int CMP_W = SUM_W + wavg_pkg::DIV_W;

	// stage 0 takes the magnitude, stages 1..Q_W resolve one quotient bit each
	logic                          vld_s [Q_W+1];
	logic                          neg_s [Q_W+1];
	logic                          ok_s  [Q_W+1];
	logic [wavg_pkg::DIV_W-1:0]    div_s [Q_W+1];
	logic [SUM_W-1:0]              rem_s [Q_W+1];
	logic [Q_W-1:0]                quo_s [Q_W+1];

	logic                          out_vld_s;
	logic signed [SAMPLE_BITS-1:0] out_filt_s;
	logic                          out_ok_s;

	logic [Q_W:0]                  rdy;
	logic                          rdy_out;

	assign rdy_out = !out_vld_s || res_ready;

	always_comb begin
		rdy[Q_W] = !vld_s[Q_W] || rdy_out;
		for (int k = Q_W - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign req_ready = rdy[0];

	// magnitude stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && req_valid) begin
			neg_s[0] <= sum[SUM_W-1];
			rem_s[0] <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
			div_s[0] <= divisor;
			ok_s[0]  <= ok;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		localparam int BIT = Q_W - k;

		logic [CMP_W-1:0] trial;
		logic             fits;
		logic [SUM_W-1:0] rem_nx;
		logic [Q_W-1:0]   quo_nx;

		always_comb begin
			trial  = CMP_W'(div_s[k-1]) << BIT;
			fits   = CMP_W'(rem_s[k-1]) >= trial;
			rem_nx = fits ? (rem_s[k-1] - trial[SUM_W-1:0]) : rem_s[k-1];
			quo_nx = quo_s[k-1];
			quo_nx[BIT] = fits;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				neg_s[k] <= neg_s[k-1];
				ok_s[k]  <= ok_s[k-1];
				div_s[k] <= div_s[k-1];
				rem_s[k] <= rem_nx;
				quo_s[k] <= quo_nx;
			end
		end
	end

	// sign restore and result register
	logic [SAMPLE_BITS-1:0] q_ext;
	logic [SAMPLE_BITS-1:0] q_sgn;

	assign q_ext = {1'b0, quo_s[Q_W]};
	assign q_sgn = neg_s[Q_W] ? (~q_ext + SAMPLE_BITS'(1)) : q_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
		end else if (rdy_out) begin
			out_vld_s <= vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s[Q_W]) begin
			out_filt_s <= q_sgn;
			out_ok_s   <= ok_s[Q_W];
		end
	end

	assign res_valid = out_vld_s;
	assign filtered  = out_filt_s;
	assign depth_ok  = out_ok_s;

endmodule

>>> hdl/windowed_average_filter_core.sv
// Windowed average filter core: prefix-sum cell chain and pipelined divider.
// Path: an accepted request passes the magnitude stage, the quotient bit stages and the result register.
// Throughput: one request per cycle while results are taken; the divider resolves one quotient bit per stage.
// Stalls ripple back stage by stage, so empty stages keep taking requests.
// Reset: window depth 10, history cleared to zero, pipeline empty.
// Depends on wavg_pkg, wavg_if, wavg_cell and wavg_div.
module windowed_average_filter_core #(
	parameter int MAX_TAPS    = wavg_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wavg_pkg::DEPTH_W-1:0] cfg_wdata,
	wavg_in_if.sink                      samples,
	wavg_out_if.source                   results
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_TAPS);

	logic [wavg_pkg::DEPTH_W-1:0] depth_q;
	logic                         ok;
	wavg_pkg::wavg_shift_t        shift;

	logic signed [SUM_W-1:0]      pfx [MAX_TAPS];
	logic signed [SUM_W-1:0]      tap [MAX_TAPS];
	logic signed [SUM_W-1:0]      tap_or;
	logic signed [SUM_W-1:0]      sum_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= wavg_pkg::DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	assign ok = (32'(depth_q) >= 32'(wavg_pkg::MIN_DEPTH)) && (32'(depth_q) <= 32'(MAX_TAPS));

	assign shift.en    = samples.valid && samples.ready;
	assign shift.clear = samples.frame_start;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic signed [SUM_W-1:0] prev;

		if (k == 0) begin : g_head
			assign prev = '0;
		end else begin : g_link
			assign prev = pfx[k-1];
		end

		wavg_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.SUM_W       (SUM_W),
			.IDX         (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.depth  (depth_q),
			.sample (samples.sample),
			.prev   (prev),
			.pfx    (pfx[k]),
			.tap    (tap[k])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int k = 0; k < MAX_TAPS; k++) begin
			tap_or = tap_or | tap[k];
		end
	end

	// frame start means an empty history, so the sum is zero
	assign sum_sel = (ok && !samples.frame_start) ? tap_or : '0;

	wavg_div #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (samples.valid),
		.req_ready (samples.ready),
		.sum       (sum_sel),
		.divisor   (wavg_pkg::DIV_W'(depth_q) + wavg_pkg::DIV_W'(1)),
		.ok        (ok),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.filtered  (results.filtered),
		.depth_ok  (results.depth_ok)
	);

endmodule

>>> hdl/wavg_chk.sv
// Port checker for the windowed average filter core, bound to the top level.
// Depends on windowed_average_filter_core_macros.svh.
`include "windowed_average_filter_core_macros.svh"

module wavg_chk #(
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [SAMPLE_BITS-1:0] filtered,
	input logic                         depth_ok
);

	`WAVG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`WAVG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(filtered) && $stable(depth_ok))
	`WAVG_ASSERT_NOW(a_bad_depth_zero, clk, arst_n, out_valid && !depth_ok, filtered == '0)
	`WAVG_ASSERT_NOW(a_ready_flows, clk, arst_n, out_ready, in_ready)

endmodule

bind windowed_average_filter_core wavg_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_wavg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.filtered  (results.filtered),
	.depth_ok  (results.depth_ok)
);

>>> bench/tb_top.sv
// Testbench for windowed_average_filter_core: directed and random sample streams with random
// idling on both channels, results checked against an in-bench window average predictor.
// Depends on wavg_pkg, wavg_if and the filter core RTL.
module tb_top;
	import wavg_pkg::*;

	localparam int PIPE_LAT = SAMPLE_BITS_DEF + 1;
	localparam int SB       = SAMPLE_BITS_DEF;

	typedef struct {
		logic signed [SB-1:0] filtered;
		logic                 depth_ok;
	} avg_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [DEPTH_W-1:0] cfg_wdata = '0;

	wavg_in_if  in_ch();
	wavg_out_if out_ch();

	windowed_average_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples  (in_ch),
		.results  (out_ch)
	);

	always #6 clk = ~clk;

	logic signed [SB-1:0] hist [MAX_TAPS_DEF];
	logic [DEPTH_W-1:0]   win_depth = DEPTH_RESET;
	avg_result_t          expected_averages[$];

	int mismatches = 0;
	int samples_sent = 0;
	int averages_checked = 0;
	int restarts = 0;
	int bad_depth_items = 0;
	int hold_left = 0;
	bit quiet = 1'b0;
	logic [15:0] depths_used = '0;

	int                   run_left = 0;
	logic signed [SB-1:0] run_val = '0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.frame_start = 1'b0;
		out_ch.ready = 1'b0;
		foreach (hist[k]) hist[k] = '0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %0d at result %0d: %s got %0d want %0d",
				mismatches, averages_checked, what, got, want);
	endtask

	function automatic avg_result_t predict_average(input logic signed [SB-1:0] s,
		input logic fs);
		avg_result_t r;
		int          sum;
		int          q;
		logic        ok;
		if (fs)
			foreach (hist[k]) hist[k] = '0;
		ok = (win_depth >= MIN_DEPTH) && (win_depth <= MAX_TAPS_DEF);
		q = 0;
		if (ok) begin
			sum = 0;
			for (int k = 0; k < int'(win_depth); k++)
				sum += hist[k];
			q = sum / (int'(win_depth) + 1);
		end
		for (int k = MAX_TAPS_DEF - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = s;
		r.filtered = SB'(q);
		r.depth_ok = ok;
		return r;
	endfunction

	function automatic logic signed [SB-1:0] next_random_sample();
		if (run_left > 0) begin
			run_left--;
			return run_val;
		end
		case ($urandom_range(19))
			0: begin
				run_left = $urandom_range(12, 4);
				run_val = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				return run_val;
			end
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3, 4, 5: return SB'(int'($urandom_range(16)) - 8);
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SB-1:0] s, input logic fs);
		avg_result_t r;
		while (!quiet && $urandom_range(99) < 20) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.frame_start <= fs;
		do @(posedge clk); while (!in_ch.ready);
		r = predict_average(s, fs);
		expected_averages.push_back(r);
		samples_sent++;
		if (fs)
			restarts++;
		if (!r.depth_ok)
			bad_depth_items++;
	endtask

	task automatic drain_pipeline();
		in_ch.valid <= 1'b0;
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_depth(input logic [DEPTH_W-1:0] d);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_depth = d;
		depths_used[d] = 1'b1;
	endtask

	// receive side: random stalls, hold-off countdown, result check
	initial begin
		avg_result_t want;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_averages.size() == 0) begin
					report_mismatch("result with nothing pending", out_ch.filtered, 0);
				end else begin
					want = expected_averages.pop_front();
					if (out_ch.filtered !== want.filtered)
						report_mismatch("filtered", out_ch.filtered, want.filtered);
					if (out_ch.depth_ok !== want.depth_ok)
						report_mismatch("depth_ok", out_ch.depth_ok, want.depth_ok);
				end
				averages_checked++;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= quiet || ($urandom_range(99) >= 20);
			end
		end
	end

	task automatic test_reset_depth_extremes();
		depths_used[DEPTH_RESET] = 1'b1;
		send_sample(16'sh7fff, 1'b1);
		repeat (9) send_sample(16'sh7fff, 1'b0);
		repeat (3) send_sample(16'sh8000, 1'b0);
	endtask

	task automatic test_depth_limits();
		set_depth(4'd2);
		send_sample(16'sh1234, 1'b0);
		send_sample(-16'sd77, 1'b0);
		set_depth(4'd15);
		send_sample(16'sh8000, 1'b0);
		set_depth(4'd0);
		send_sample(16'sh7fff, 1'b1);
		set_depth(4'd11);
		send_sample(16'sd5, 1'b0);
		// truncation toward zero on both signs, restart with stale history
		set_depth(4'd3);
		send_sample(-16'sd1, 1'b1);
		send_sample(-16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd7, 1'b0);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd0, 1'b0);
	endtask

	task automatic test_random_stream();
		logic [DEPTH_W-1:0] d;
		for (int phase = 0; phase < 11; phase++) begin
			case (phase)
				0: d = 4'd15;
				1: d = 4'd3;
				2: d = 4'd0;
				3: d = 4'd10;
				default: d = ($urandom_range(3) == 0) ? DEPTH_W'($urandom_range(15))
					: DEPTH_W'($urandom_range(MAX_TAPS_DEF, MIN_DEPTH));
			endcase
			set_depth(d);
			for (int n = 0; n < 155; n++)
				send_sample(next_random_sample(), $urandom_range(99) < 3);
		end
	endtask

	task automatic test_output_stall();
		set_depth(4'd7);
		hold_left = 200;
		for (int n = 0; n < 120; n++)
			send_sample(next_random_sample(), $urandom_range(99) < 3);
	endtask

	task automatic test_no_gaps();
		set_depth(DEPTH_RESET);
		quiet = 1'b1;
		for (int n = 0; n < 120; n++)
			send_sample(next_random_sample(), $urandom_range(99) < 3);
		quiet = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_depth_extremes();
		test_depth_limits();
		test_random_stream();
		test_output_stall();
		test_no_gaps();
		in_ch.valid <= 1'b0;
		for (int w = 0; w < 5000 && expected_averages.size() != 0; w++)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (expected_averages.size() != 0)
			report_mismatch("results never delivered", expected_averages.size(), 0);
		$display("covered %0d samples, %0d averages checked, %0d frame restarts,",
			samples_sent, averages_checked, restarts);
		$display("%0d items at out-of-range depth, depth settings used mask %h",
			bad_depth_items, depths_used);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2400000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
